// File: rtl/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared types and constants for the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

	localparam int VEC_W  = 32;
	localparam int QUAT_W = 16;
	localparam int COEF_W = 34;
	localparam int PH_W   = 50;
	localparam int PL_W   = 51;
	localparam int HI_W   = 52;
	localparam int LO_W   = 53;
	localparam int TOT_W  = 70;
	localparam int ROT_W  = 40;
	localparam int DIF_W  = 41;

	localparam logic [1:0] FUNC_W2B  = 2'd0;
	localparam logic [1:0] FUNC_B2W  = 2'd1;
	localparam logic [1:0] FUNC_GRAV = 2'd2;
	localparam logic [1:0] FUNC_NONE = 2'd3;

	localparam logic signed [VEC_W-1:0] GRAVITY_RST = 32'sd642689;
	localparam logic signed [VEC_W-1:0] Q32_MAX     = 32'sh7fff_ffff;
	localparam logic signed [VEC_W-1:0] Q32_MIN     = 32'sh8000_0000;

	typedef struct packed {
		logic [1:0]               func;
		logic signed [VEC_W-1:0]  vec_x;
		logic signed [VEC_W-1:0]  vec_y;
		logic signed [VEC_W-1:0]  vec_z;
		logic signed [QUAT_W-1:0] quat_w;
		logic signed [QUAT_W-1:0] quat_x;
		logic signed [QUAT_W-1:0] quat_y;
		logic signed [QUAT_W-1:0] quat_z;
	} cmd_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] out_x;
		logic signed [VEC_W-1:0] out_y;
		logic signed [VEC_W-1:0] out_z;
		logic                    saturated;
	} result_t;

	// index 0 is x
	typedef logic [2:0][VEC_W-1:0] vec3_t;
	typedef logic [2:0][ROT_W-1:0] rot_t;
	typedef logic [2:0][2:0][COEF_W-1:0] coef_t;

	// per-item control carried alongside the datapath
	typedef struct packed {
		logic [1:0] func;
		vec3_t      vec;
	} tag_t;

endpackage

// File: rtl/qvr_coef.sv
// ----------------------------------------------------------------------------
// qvr_coef
// Stages 1-2: quaternion products and the 3x3 rotation coefficients.
// ----------------------------------------------------------------------------
module qvr_coef (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  qvr_pkg::cmd_t                         cmd,
	input  logic signed [qvr_pkg::VEC_W-1:0]      gravity,
	output logic                                  valid_s2,
	output qvr_pkg::tag_t                         tag_s2,
	output qvr_pkg::coef_t                        coef_s2,
	output qvr_pkg::vec3_t                        opnd_s2
);

	logic                                valid_s1;
	qvr_pkg::tag_t                       tag_s1;
	qvr_pkg::vec3_t                      opnd_s1;
	logic signed [2*qvr_pkg::QUAT_W-1:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [2*qvr_pkg::QUAT_W-1:0] xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;
	logic signed [qvr_pkg::COEF_W-1:0]   m [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1.func <= cmd.func;
			tag_s1.vec  <= {cmd.vec_z, cmd.vec_y, cmd.vec_x};
			if (cmd.func == qvr_pkg::FUNC_GRAV) begin
				opnd_s1 <= {gravity, 32'd0, 32'd0};
			end else begin
				opnd_s1 <= {cmd.vec_z, cmd.vec_y, cmd.vec_x};
			end
			ww_s1 <= 32'(cmd.quat_w) * 32'(cmd.quat_w);
			xx_s1 <= 32'(cmd.quat_x) * 32'(cmd.quat_x);
			yy_s1 <= 32'(cmd.quat_y) * 32'(cmd.quat_y);
			zz_s1 <= 32'(cmd.quat_z) * 32'(cmd.quat_z);
			xy_s1 <= 32'(cmd.quat_x) * 32'(cmd.quat_y);
			wz_s1 <= 32'(cmd.quat_w) * 32'(cmd.quat_z);
			xz_s1 <= 32'(cmd.quat_x) * 32'(cmd.quat_z);
			wy_s1 <= 32'(cmd.quat_w) * 32'(cmd.quat_y);
			yz_s1 <= 32'(cmd.quat_y) * 32'(cmd.quat_z);
			wx_s1 <= 32'(cmd.quat_w) * 32'(cmd.quat_x);
		end
	end

	// world to body matrix
	always_comb begin
		m[0][0] = 34'(ww_s1) + 34'(xx_s1) - 34'(yy_s1) - 34'(zz_s1);
		m[0][1] = (34'(xy_s1) + 34'(wz_s1)) <<< 1;
		m[0][2] = (34'(xz_s1) - 34'(wy_s1)) <<< 1;
		m[1][0] = (34'(xy_s1) - 34'(wz_s1)) <<< 1;
		m[1][1] = 34'(ww_s1) - 34'(xx_s1) + 34'(yy_s1) - 34'(zz_s1);
		m[1][2] = (34'(yz_s1) + 34'(wx_s1)) <<< 1;
		m[2][0] = (34'(xz_s1) + 34'(wy_s1)) <<< 1;
		m[2][1] = (34'(yz_s1) - 34'(wx_s1)) <<< 1;
		m[2][2] = 34'(ww_s1) - 34'(xx_s1) - 34'(yy_s1) + 34'(zz_s1);
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			tag_s2  <= tag_s1;
			opnd_s2 <= opnd_s1;
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					if (tag_s1.func == qvr_pkg::FUNC_B2W) begin
						coef_s2[i][k] <= m[k][i];
					end else begin
						coef_s2[i][k] <= m[i][k];
					end
				end
			end
		end
	end

endmodule

// File: rtl/qvr_mac.sv
// ----------------------------------------------------------------------------
// qvr_mac
// Stages 3-5: coefficient by vector products, row sums, scale by 2^-28.
// ----------------------------------------------------------------------------
module qvr_mac (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s2,
	input  qvr_pkg::tag_t  tag_s2,
	input  qvr_pkg::coef_t coef_s2,
	input  qvr_pkg::vec3_t opnd_s2,
	output logic           valid_s5,
	output qvr_pkg::tag_t  tag_s5,
	output qvr_pkg::rot_t  rot_s5
);

	logic                             valid_s3, valid_s4;
	qvr_pkg::tag_t                    tag_s3, tag_s4;
	logic signed [qvr_pkg::PH_W-1:0]  ph_s3 [3][3];
	logic signed [qvr_pkg::PL_W-1:0]  pl_s3 [3][3];
	logic signed [qvr_pkg::HI_W-1:0]  hi_s4 [3];
	logic signed [qvr_pkg::LO_W-1:0]  lo_s4 [3];
	logic signed [qvr_pkg::TOT_W-1:0] tot [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// split each vector word into a signed high half and an unsigned low half
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			tag_s3 <= tag_s2;
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					ph_s3[i][k] <= 50'($signed(coef_s2[i][k]))
						* 50'($signed(opnd_s2[k][31:16]));
					pl_s3[i][k] <= 51'($signed(coef_s2[i][k]))
						* 51'($signed({1'b0, opnd_s2[k][15:0]}));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			tag_s4 <= tag_s3;
			for (int i = 0; i < 3; i++) begin
				hi_s4[i] <= 52'(ph_s3[i][0]) + 52'(ph_s3[i][1]) + 52'(ph_s3[i][2]);
				lo_s4[i] <= 53'(pl_s3[i][0]) + 53'(pl_s3[i][1]) + 53'(pl_s3[i][2]);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tot[i] = (70'(hi_s4[i]) <<< 16) + 70'(lo_s4[i]);
		end
	end

	// floor by 2^28
	always_ff @(posedge clk) begin
		if (valid_s4) begin
			tag_s5 <= tag_s4;
			for (int i = 0; i < 3; i++) begin
				rot_s5[i] <= tot[i][67:28];
			end
		end
	end

endmodule

// File: rtl/qvr_post.sv
// ----------------------------------------------------------------------------
// qvr_post
// Stage 6: gravity subtraction, saturation and the result register.
// ----------------------------------------------------------------------------
module qvr_post (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s5,
	input  qvr_pkg::tag_t    tag_s5,
	input  qvr_pkg::rot_t    rot_s5,
	output logic             done_s6,
	output qvr_pkg::result_t res_s6
);

	logic signed [qvr_pkg::DIF_W-1:0] dif [3];
	logic signed [qvr_pkg::VEC_W-1:0] clp [3];
	logic [2:0]                       sat;
	qvr_pkg::result_t                 res_nxt;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (tag_s5.func == qvr_pkg::FUNC_GRAV) begin
				dif[i] = 41'($signed(tag_s5.vec[i])) - 41'($signed(rot_s5[i]));
			end else begin
				dif[i] = 41'($signed(rot_s5[i]));
			end
			if (dif[i] > 41'(qvr_pkg::Q32_MAX)) begin
				clp[i] = qvr_pkg::Q32_MAX;
				sat[i] = 1'b1;
			end else if (dif[i] < 41'(qvr_pkg::Q32_MIN)) begin
				clp[i] = qvr_pkg::Q32_MIN;
				sat[i] = 1'b1;
			end else begin
				clp[i] = dif[i][31:0];
				sat[i] = 1'b0;
			end
		end
		if (tag_s5.func == qvr_pkg::FUNC_NONE) begin
			res_nxt = '0;
		end else begin
			res_nxt.out_x     = clp[0];
			res_nxt.out_y     = clp[1];
			res_nxt.out_z     = clp[2];
			res_nxt.saturated = |sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s6 <= 1'b0;
		end else begin
			done_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s5) begin
			res_s6 <= res_nxt;
		end
	end

endmodule

// File: rtl/quaternion_vector_rotate_top.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_top
// Rotates a Q16.16 vector by a Q2.14 quaternion, either direction, or
// removes rotated gravity; floored by 2^28 and saturated to 32 bits.
//
//   channel   control         payload
//   command   start / busy    cmd    (qvr_pkg::cmd_t)
//   result    done            result (qvr_pkg::result_t)
//   gravity   cfg_we          cfg_wdata
//
// One command transfer per cycle while busy is low; its result shows on done
// after the transfer, at the end of the six-stage multiply and sum pipeline.
// busy is high in reset and until the first clock after it, low otherwise.
// The result side has no back-pressure, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  qvr_pkg::cmd_t                     cmd,
	input  logic                              cfg_we,
	input  logic signed [qvr_pkg::VEC_W-1:0]  cfg_wdata,
	output logic                              done,
	output qvr_pkg::result_t                  result
);

	logic                             busy_q;
	logic signed [qvr_pkg::VEC_W-1:0] gravity_q;
	logic                             accept;
	logic                             valid_s2, valid_s5;
	qvr_pkg::tag_t                    tag_s2, tag_s5;
	qvr_pkg::coef_t                   coef_s2;
	qvr_pkg::vec3_t                   opnd_s2;
	qvr_pkg::rot_t                    rot_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			gravity_q <= qvr_pkg::GRAVITY_RST;
		end else begin
			busy_q <= 1'b0;
			if (cfg_we) begin
				gravity_q <= cfg_wdata;
			end
		end
	end

	assign busy   = busy_q;
	assign accept = start & ~busy_q;

	qvr_coef u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (cmd),
		.gravity  (gravity_q),
		.valid_s2 (valid_s2),
		.tag_s2   (tag_s2),
		.coef_s2  (coef_s2),
		.opnd_s2  (opnd_s2)
	);

	qvr_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.tag_s2   (tag_s2),
		.coef_s2  (coef_s2),
		.opnd_s2  (opnd_s2),
		.valid_s5 (valid_s5),
		.tag_s5   (tag_s5),
		.rot_s5   (rot_s5)
	);

	qvr_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s5 (valid_s5),
		.tag_s5   (tag_s5),
		.rot_s5   (rot_s5),
		.done_s6  (done),
		.res_s6   (result)
	);

endmodule

// File: rtl/qvr_checker.sv
// ----------------------------------------------------------------------------
// qvr_checker
// Port-level checks on transfer latency, spurious results, unused codes, saturation and gravity writes.
// ----------------------------------------------------------------------------
module qvr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input qvr_pkg::cmd_t                     cmd,
	input logic                              cfg_we,
	input logic signed [qvr_pkg::VEC_W-1:0]  cfg_wdata,
	input logic                              done,
	input qvr_pkg::result_t                  result
);

	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done)
		else $error("transfer without result");

	a_no_spurious : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 6))
		else $error("result without transfer");

	a_unused_code : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.func == qvr_pkg::FUNC_NONE && !cfg_we) |-> ##6
		(result.out_x == '0 && result.out_y == '0 && result.out_z == '0 &&
		 !result.saturated))
		else $error("unused code gave nonzero result");

	a_sat_clip : assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.saturated) |->
		(result.out_x == qvr_pkg::Q32_MAX || result.out_x == qvr_pkg::Q32_MIN ||
		 result.out_y == qvr_pkg::Q32_MAX || result.out_y == qvr_pkg::Q32_MIN ||
		 result.out_z == qvr_pkg::Q32_MAX || result.out_z == qvr_pkg::Q32_MIN))
		else $error("saturated flag without a clipped component");

	a_cfg_value : assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !$isunknown(cfg_wdata))
		else $error("unknown gravity write");

endmodule

bind quaternion_vector_rotate_top qvr_checker u_qvr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.cmd       (cmd),
	.cfg_we    (cfg_we),
	.cfg_wdata (cfg_wdata),
	.done      (done),
	.result    (result)
);
